[hdl/ttia_pkg.sv]
// ----------------------------------------------------------------------------
// ttia_pkg
// Shared types, register indexes and helpers for the twin thruster
// inverse allocation block.
// ----------------------------------------------------------------------------
package ttia_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int CoefW    = 48;
  localparam int FixW     = 32;
  localparam int VelW     = 49;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUAD_FWD  = 3'd0,
    CFG_SPEED_FWD = 3'd1,
    CFG_QUAD_REV  = 3'd2,
    CFG_SPEED_REV = 3'd3,
    CFG_RPP_FWD   = 3'd4,
    CFG_RPP_REV   = 3'd5,
    CFG_LEVER_ARM = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [CoefW-1:0] quad_fwd;
    logic [CoefW-1:0] speed_fwd;
    logic [CoefW-1:0] quad_rev;
    logic [CoefW-1:0] speed_rev;
    logic [FixW-1:0]  rpp_fwd;
    logic [FixW-1:0]  rpp_rev;
    logic [FixW-1:0]  lever_arm;
  } cfg_t;

  typedef struct packed {
    logic                   vld;
    logic signed [FixW-1:0] thrust;
    logic signed [VelW-1:0] vel;
  } lane_in_t;

  typedef struct packed {
    logic                   vld;
    logic signed [FixW-1:0] pct;
  } lane_out_t;

  // signed 32 bit saturation of a sign and magnitude pair
  function automatic logic [FixW-1:0] sat_s32(input logic neg, input logic [FixW-1:0] mag);
    logic [FixW-1:0] res;
    if (neg) begin
      res = mag[FixW-1] ? {1'b1, {(FixW-1){1'b0}}} : (~mag + 1'b1);
    end else begin
      res = mag[FixW-1] ? {1'b0, {(FixW-1){1'b1}}} : mag;
    end
    return res;
  endfunction

endpackage

[hdl/ttia_div.sv]
// ----------------------------------------------------------------------------
// ttia_div
// Pipelined restoring divider, one quotient bit per stage. The high part of
// the dividend must be below the divisor; overflow is judged by the caller.
// ----------------------------------------------------------------------------
module ttia_div #(
  parameter int DW  = 32,
  parameter int QW  = 32,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [DW-1:0]  in_hi,
  input  logic [QW-1:0]  in_lo,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QW-1:0]  out_quo,
  output logic [SBW-1:0] out_sb
);

  logic           vld_r [QW];
  logic [DW-1:0]  rem_r [QW];
  logic [QW-1:0]  lo_r  [QW];
  logic [QW-1:0]  quo_r [QW];
  logic [DW-1:0]  den_r [QW];
  logic [SBW-1:0] sb_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic           vld_prev;
    logic [DW-1:0]  rem_prev;
    logic [QW-1:0]  lo_prev;
    logic [QW-1:0]  quo_prev;
    logic [DW-1:0]  den_prev;
    logic [SBW-1:0] sb_prev;
    logic [DW:0]    trial;
    logic [DW:0]    diff;

    if (i == 0) begin : g_first
      assign vld_prev = in_vld;
      assign rem_prev = in_hi;
      assign lo_prev  = in_lo;
      assign quo_prev = '0;
      assign den_prev = in_den;
      assign sb_prev  = in_sb;
    end else begin : g_next
      assign vld_prev = vld_r[i-1];
      assign rem_prev = rem_r[i-1];
      assign lo_prev  = lo_r[i-1];
      assign quo_prev = quo_r[i-1];
      assign den_prev = den_r[i-1];
      assign sb_prev  = sb_r[i-1];
    end

    assign trial = {rem_prev, lo_prev[QW-1]};
    assign diff  = trial - {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_prev}) begin
          rem_r[i] <= diff[DW-1:0];
          quo_r[i] <= {quo_prev[QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[DW-1:0];
          quo_r[i] <= {quo_prev[QW-2:0], 1'b0};
        end
        lo_r[i]  <= {lo_prev[QW-2:0], 1'b0};
        den_r[i] <= den_prev;
        sb_r[i]  <= sb_prev;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = quo_r[QW-1];
  assign out_sb  = sb_r[QW-1];

endmodule

[hdl/ttia_sqrt.sv]
// ----------------------------------------------------------------------------
// ttia_sqrt
// Pipelined integer square root, one root bit per stage (digit by digit
// with a running remainder).
// ----------------------------------------------------------------------------
module ttia_sqrt #(
  parameter int RW  = 57,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output logic [SBW-1:0]  out_sb
);

  logic            vld_r  [RW];
  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [SBW-1:0]  sb_r   [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            vld_prev;
    logic [RW:0]     rem_prev;
    logic [RW-1:0]   root_prev;
    logic [2*RW-1:0] rad_prev;
    logic [SBW-1:0]  sb_prev;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;

    if (i == 0) begin : g_first
      assign vld_prev  = in_vld;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = in_rad;
      assign sb_prev   = in_sb;
    end else begin : g_next
      assign vld_prev  = vld_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
      assign rad_prev  = rad_r[i-1];
      assign sb_prev   = sb_r[i-1];
    end

    assign rem2  = {rem_prev, rad_prev[2*RW-1 -: 2]};
    assign trial = {1'b0, root_prev, 2'b01};
    assign diff  = rem2 - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem2 >= trial) begin
          rem_r[i]  <= diff[RW:0];
          root_r[i] <= {root_prev[RW-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem2[RW:0];
          root_r[i] <= {root_prev[RW-2:0], 1'b0};
        end
        rad_r[i] <= {rad_prev[2*RW-3:0], 2'b00};
        sb_r[i]  <= sb_prev;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

[hdl/ttia_lane.sv]
// ----------------------------------------------------------------------------
// ttia_lane
// One thruster: advance term, discriminant, square root, root selection,
// root division and conversion of speed to a command percentage.
// ----------------------------------------------------------------------------
module ttia_lane import ttia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  cfg_t      cfg,
  input  lane_in_t  lane_in,
  output lane_out_t lane_out
);

  localparam int PmW   = 56;
  localparam int SqW   = 57;
  localparam int NumW  = 59;
  localparam int QcfW  = 58;
  localparam int RtSbW = 1 + CoefW + SqW;

  // ---- stage 1: partial products of b2*|v| and b1*|F|
  logic               s1_vld_r, s1_fwd_r, s1_vneg_r;
  logic [CoefW-1:0]   s1_qc_r;
  logic [47:0]        s1_hh_r, s1_hl_r, s1_lh_r, s1_ll_r;
  logic [55:0]        s1_qh_r, s1_ql_r;
  logic               s1_fwd_nxt;
  logic [CoefW-1:0]   s1_qc_nxt, s1_sc;
  logic [VelW-1:0]    s1_vabs;
  logic [FixW:0]      s1_fabs;
  logic [47:0]        s1_vmag;
  logic [FixW-1:0]    s1_fmag;

  always_comb begin
    s1_fwd_nxt = (lane_in.thrust > 0);
    s1_qc_nxt  = s1_fwd_nxt ? cfg.quad_fwd  : cfg.quad_rev;
    s1_sc      = s1_fwd_nxt ? cfg.speed_fwd : cfg.speed_rev;
    s1_vabs    = lane_in.vel[VelW-1] ? -lane_in.vel : lane_in.vel;
    s1_vmag    = s1_vabs[47:0];
    s1_fabs    = lane_in.thrust[FixW-1] ? -{lane_in.thrust[FixW-1], lane_in.thrust}
                                        : {lane_in.thrust[FixW-1], lane_in.thrust};
    s1_fmag    = s1_fabs[FixW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= lane_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fwd_r  <= s1_fwd_nxt;
      s1_vneg_r <= lane_in.vel[VelW-1];
      s1_qc_r   <= s1_qc_nxt;
      s1_hh_r   <= {24'b0, s1_sc[47:24]} * {24'b0, s1_vmag[47:24]};
      s1_hl_r   <= {24'b0, s1_sc[47:24]} * {24'b0, s1_vmag[23:0]};
      s1_lh_r   <= {24'b0, s1_sc[23:0]}  * {24'b0, s1_vmag[47:24]};
      s1_ll_r   <= {24'b0, s1_sc[23:0]}  * {24'b0, s1_vmag[23:0]};
      s1_qh_r   <= {32'b0, s1_qc_nxt[47:24]} * {24'b0, s1_fmag};
      s1_ql_r   <= {32'b0, s1_qc_nxt[23:0]}  * {24'b0, s1_fmag};
    end
  end

  // ---- stage 2: sums, p magnitude and 4*b1*|F| in Q26.32
  logic               s2_vld_r, s2_fwd_r, s2_vneg_r;
  logic [CoefW-1:0]   s2_qc_r;
  logic [PmW-1:0]     s2_pm_r;
  logic [QcfW-1:0]    s2_qcf_r;
  logic [95:0]        s2_sv;
  logic [79:0]        s2_qf;

  always_comb begin
    s2_sv = {s1_hh_r, 48'b0} + {24'b0, s1_hl_r, 24'b0} + {24'b0, s1_lh_r, 24'b0}
          + {48'b0, s1_ll_r};
    s2_qf = {s1_qh_r, 24'b0} + {24'b0, s1_ql_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_fwd_r  <= s1_fwd_r;
      s2_vneg_r <= s1_vneg_r;
      s2_qc_r   <= s1_qc_r;
      s2_pm_r   <= s2_sv[95:40];
      s2_qcf_r  <= s2_qf[79:22];
    end
  end

  // ---- stage 3: partial products of p*p
  logic               s3_vld_r, s3_fwd_r, s3_vneg_r;
  logic [CoefW-1:0]   s3_qc_r;
  logic [PmW-1:0]     s3_pm_r;
  logic [QcfW-1:0]    s3_qcf_r;
  logic [55:0]        s3_aa_r, s3_ab_r, s3_bb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fwd_r  <= s2_fwd_r;
      s3_vneg_r <= s2_vneg_r;
      s3_qc_r   <= s2_qc_r;
      s3_pm_r   <= s2_pm_r;
      s3_qcf_r  <= s2_qcf_r;
      s3_aa_r   <= {28'b0, s2_pm_r[55:28]} * {28'b0, s2_pm_r[55:28]};
      s3_ab_r   <= {28'b0, s2_pm_r[55:28]} * {28'b0, s2_pm_r[27:0]};
      s3_bb_r   <= {28'b0, s2_pm_r[27:0]}  * {28'b0, s2_pm_r[27:0]};
    end
  end

  // ---- stage 4: discriminant and signed p
  logic               s4_vld_r;
  logic [2*SqW-1:0]   s4_delta_r;
  logic [RtSbW-1:0]   s4_sb_r;
  logic [2*SqW-1:0]   s4_delta_nxt;
  logic [SqW-1:0]     s4_p;

  always_comb begin
    s4_delta_nxt = {2'b0, s3_aa_r, 56'b0} + {29'b0, s3_ab_r, 29'b0}
                 + {58'b0, s3_bb_r} + {56'b0, s3_qcf_r};
    s4_p         = s3_vneg_r ? -{1'b0, s3_pm_r} : {1'b0, s3_pm_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_delta_r <= s4_delta_nxt;
      s4_sb_r    <= {s3_fwd_r, s3_qc_r, s4_p};
    end
  end

  logic             sq_vld;
  logic [SqW-1:0]   sq_root;
  logic [RtSbW-1:0] sq_sb;

  ttia_sqrt #(.RW(SqW), .SBW(RtSbW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4_vld_r),
    .in_rad   (s4_delta_r),
    .in_sb    (s4_sb_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // ---- stage 5: pick the root numerator
  // a numerator whose quotient truncates to zero counts as zero
  function automatic logic root_nz(input logic [NumW-1:0] num, input logic [CoefW-1:0] qc);
    logic [NumW-1:0] mag;
    logic            ge;
    mag = num[NumW-1] ? -num : num;
    ge  = ({mag[NumW-2:0], 39'b0} >= {49'b0, qc});
    return (num != '0) && ((qc == '0) || ge);
  endfunction

  logic               s5_vld_r, s5_neg_r;
  logic [NumW-2:0]    s5_nmag_r;
  logic [CoefW-1:0]   s5_qc_r;
  logic               s5_fwd;
  logic [CoefW-1:0]   s5_qc;
  logic [SqW-1:0]     s5_p;
  logic [NumW-1:0]    s5_sum, s5_dif, s5_num, s5_nabs;

  always_comb begin
    s5_fwd = sq_sb[RtSbW-1];
    s5_qc  = sq_sb[SqW +: CoefW];
    s5_p   = sq_sb[SqW-1:0];
    s5_sum = {{2{s5_p[SqW-1]}}, s5_p} + {2'b0, sq_root};
    s5_dif = {{2{s5_p[SqW-1]}}, s5_p} - {2'b0, sq_root};
    if (s5_fwd) begin
      s5_num = (!s5_sum[NumW-1] && root_nz(s5_sum, s5_qc)) ? s5_sum : s5_dif;
    end else begin
      s5_num = (s5_dif[NumW-1] && root_nz(s5_dif, s5_qc)) ? s5_dif : s5_sum;
    end
    s5_nabs = s5_num[NumW-1] ? -s5_num : s5_num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_neg_r  <= s5_num[NumW-1];
      s5_nmag_r <= s5_nabs[NumW-2:0];
      s5_qc_r   <= s5_qc;
    end
  end

  // ---- root division: |num| * 2^39 / b1, capped at 2^47
  logic [CoefW:0]   rd_hi;
  logic             rd_ovf, rd_zero;
  logic             rd_vld;
  logic [CoefW-1:0] rd_quo;
  logic [2:0]       rd_sb;

  always_comb begin
    rd_hi   = s5_nmag_r[NumW-2:9];
    rd_ovf  = (rd_hi >= {1'b0, s5_qc_r});
    rd_zero = (s5_nmag_r == '0);
  end

  ttia_div #(.DW(CoefW), .QW(CoefW), .SBW(3)) u_root_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s5_vld_r),
    .in_hi   (rd_hi[CoefW-1:0]),
    .in_lo   ({s5_nmag_r[8:0], 39'b0}),
    .in_den  (s5_qc_r),
    .in_sb   ({s5_neg_r, rd_ovf, rd_zero}),
    .out_vld (rd_vld),
    .out_quo (rd_quo),
    .out_sb  (rd_sb)
  );

  // ---- stage 7: speed magnitude and lambda choice
  localparam logic [CoefW-1:0] RootCap = {1'b1, {(CoefW-1){1'b0}}};

  logic               s7_vld_r, s7_neg_r;
  logic [CoefW-1:0]   s7_m_r;
  logic [FixW-1:0]    s7_lam_r;
  logic [CoefW-1:0]   s7_m_nxt;

  always_comb begin
    if (rd_sb[0]) begin
      s7_m_nxt = '0;
    end else if (rd_sb[1] || (rd_quo > RootCap)) begin
      s7_m_nxt = RootCap;
    end else begin
      s7_m_nxt = rd_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_neg_r <= rd_sb[2];
      s7_m_r   <= s7_m_nxt;
      s7_lam_r <= (!rd_sb[2] && (s7_m_nxt != '0)) ? cfg.rpp_fwd : cfg.rpp_rev;
    end
  end

  // ---- percent division: |speed| * 2^16 / lambda
  logic             pd_ovf, pd_zero, pd_vld;
  logic [FixW-1:0]  pd_quo;
  logic [2:0]       pd_sb;

  always_comb begin
    pd_ovf  = (s7_m_r[CoefW-1:16] >= s7_lam_r);
    pd_zero = (s7_m_r == '0);
  end

  ttia_div #(.DW(FixW), .QW(FixW), .SBW(3)) u_pct_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s7_vld_r),
    .in_hi   (s7_m_r[CoefW-1:16]),
    .in_lo   ({s7_m_r[15:0], 16'b0}),
    .in_den  (s7_lam_r),
    .in_sb   ({s7_neg_r, pd_ovf, pd_zero}),
    .out_vld (pd_vld),
    .out_quo (pd_quo),
    .out_sb  (pd_sb)
  );

  // ---- stage 9: saturation
  logic [FixW-1:0] s9_mag;

  always_comb begin
    if (pd_sb[0]) begin
      s9_mag = '0;
    end else if (pd_sb[1]) begin
      s9_mag = '1;
    end else begin
      s9_mag = pd_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_out.vld <= 1'b0;
    end else if (en) begin
      lane_out.vld <= pd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.pct <= sat_s32(pd_sb[2], s9_mag);
    end
  end

endmodule

[hdl/twin_thruster_inverse_allocation.sv]
// ----------------------------------------------------------------------------
// twin_thruster_inverse_allocation
// Splits a surge force and yaw moment over two thrusters and turns each
// side force into a propeller command percentage.
//
// in_tdata  carries one command item; out_tdata/out_tuser carry one result
// item per command, in order. cfg_we writes register cfg_addr from cfg_wdata.
// The user must write only while the pipeline is empty; nothing enforces it.
// The pipeline holds a 32 stage moment divider, two front end stages,
// four multiply stages, a 57 stage square root, one root select stage,
// a 48 stage root divider, one stage, a 32 stage percent divider, one
// saturation stage and the output register. Both thrusters run in
// parallel lanes; one item is taken every cycle unless the pipeline holds.
// The whole pipeline advances together: when out_tvalid is high and
// out_tready low, the pipeline holds and in_tready drops; nothing is lost.
// Reset clears all valid bits and loads the default coefficients
// (b1 = 1.0, b2 = 0, lambda = 1.0, lever arm = 1.0).
// The no-solution flags in out_tuser are always zero: the discriminant
// cannot go negative with unsigned coefficients.
// ----------------------------------------------------------------------------
module twin_thruster_inverse_allocation import ttia_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // surge_force, yaw_moment, surge_velocity, yaw_rate
  input  logic [127:0]        in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // port_percent, starboard_percent
  output logic [63:0]         out_tdata,
  // port_no_solution, starboard_no_solution
  output logic [1:0]          out_tuser,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic en;
  cfg_t cfg_r;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quad_fwd  <= 48'h010000000000;
      cfg_r.speed_fwd <= '0;
      cfg_r.quad_rev  <= 48'h010000000000;
      cfg_r.speed_rev <= '0;
      cfg_r.rpp_fwd   <= 32'h00010000;
      cfg_r.rpp_rev   <= 32'h00010000;
      cfg_r.lever_arm <= 32'h00010000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_QUAD_FWD:  cfg_r.quad_fwd  <= cfg_wdata;
        CFG_SPEED_FWD: cfg_r.speed_fwd <= cfg_wdata;
        CFG_QUAD_REV:  cfg_r.quad_rev  <= cfg_wdata;
        CFG_SPEED_REV: cfg_r.speed_rev <= cfg_wdata;
        CFG_RPP_FWD:   cfg_r.rpp_fwd   <= cfg_wdata[FixW-1:0];
        CFG_RPP_REV:   cfg_r.rpp_rev   <= cfg_wdata[FixW-1:0];
        CFG_LEVER_ARM: cfg_r.lever_arm <= cfg_wdata[FixW-1:0];
        default: ;
      endcase
    end
  end

  // ---- moment over lever arm
  logic signed [FixW-1:0] in_force, in_moment, in_vel, in_rate;
  logic [FixW:0]          nabs;
  logic [FixW-1:0]        md_hi;
  logic                   md_ovf, md_zero;
  localparam int MdSbW = 3 * FixW + 3;

  always_comb begin
    in_force  = in_tdata[31:0];
    in_moment = in_tdata[63:32];
    in_vel    = in_tdata[95:64];
    in_rate   = in_tdata[127:96];
    nabs      = in_moment[FixW-1] ? -{1'b1, in_moment} : {1'b0, in_moment};
    md_hi     = {16'b0, nabs[31:16]};
    md_ovf    = (md_hi >= cfg_r.lever_arm);
    md_zero   = (in_moment == '0);
  end

  logic             md_vld;
  logic [FixW-1:0]  md_quo;
  logic [MdSbW-1:0] md_sb;

  ttia_div #(.DW(FixW), .QW(FixW), .SBW(MdSbW)) u_moment_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_hi   (md_hi),
    .in_lo   ({nabs[15:0], 16'b0}),
    .in_den  (cfg_r.lever_arm),
    .in_sb   ({in_force, in_vel, in_rate, in_moment[FixW-1], md_ovf, md_zero}),
    .out_vld (md_vld),
    .out_quo (md_quo),
    .out_sb  (md_sb)
  );

  // ---- front stage 1: saturated quotient and r*d product
  logic                   f1_vld_r, f1_rneg_r;
  logic signed [FixW-1:0] f1_x_r, f1_u_r, f1_q_r;
  logic [2*FixW-1:0]      f1_trd_r;
  logic [FixW-1:0]        f1_qm, f1_r, f1_rmag;

  always_comb begin
    if (md_sb[0]) begin
      f1_qm = '0;
    end else if (md_sb[1]) begin
      f1_qm = '1;
    end else begin
      f1_qm = md_quo;
    end
    f1_r    = md_sb[FixW+2:3];
    f1_rmag = f1_r[FixW-1] ? (~f1_r + 1'b1) : f1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= md_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_x_r    <= md_sb[MdSbW-1 -: FixW];
      f1_u_r    <= md_sb[2*FixW+2 -: FixW];
      f1_q_r    <= sat_s32(md_sb[2], f1_qm);
      f1_rneg_r <= f1_r[FixW-1];
      f1_trd_r  <= {32'b0, f1_rmag} * {32'b0, cfg_r.lever_arm};
    end
  end

  // ---- front stage 2: side forces and advance speeds
  lane_in_t lane_p_r, lane_s_r;
  logic signed [FixW:0]   sp, ss, sp_adj, ss_adj;
  logic signed [VelW-1:0] tpos, ts, uext;

  always_comb begin
    sp     = {f1_x_r[FixW-1], f1_x_r} + {f1_q_r[FixW-1], f1_q_r};
    ss     = {f1_x_r[FixW-1], f1_x_r} - {f1_q_r[FixW-1], f1_q_r};
    // halve with truncation toward zero
    sp_adj = sp + {{FixW{1'b0}}, sp[FixW]};
    ss_adj = ss + {{FixW{1'b0}}, ss[FixW]};
    tpos   = {2'b0, f1_trd_r[62:16]};
    ts     = f1_rneg_r ? -tpos : tpos;
    uext   = {{(VelW-FixW){f1_u_r[FixW-1]}}, f1_u_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_p_r.vld <= 1'b0;
      lane_s_r.vld <= 1'b0;
    end else if (en) begin
      lane_p_r.vld <= f1_vld_r;
      lane_s_r.vld <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_p_r.thrust <= sp_adj[FixW:1];
      lane_s_r.thrust <= ss_adj[FixW:1];
      lane_p_r.vel    <= uext + ts;
      lane_s_r.vel    <= uext - ts;
    end
  end

  // ---- thruster lanes
  lane_out_t port_out, stbd_out;

  ttia_lane u_lane_port (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .lane_in  (lane_p_r),
    .lane_out (port_out)
  );

  ttia_lane u_lane_stbd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .lane_in  (lane_s_r),
    .lane_out (stbd_out)
  );

  // ---- merge and output register
  logic            out_vld_r;
  logic [63:0]     out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= port_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {stbd_out.pct, port_out.pct};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = '0;

endmodule
